[src/mvpd_pkg.sv]
`default_nettype none
package mvpd_pkg;

  // parking states
  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_ARRIVING = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRESENCE_THR = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CALIB_WINDOW = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ARRIVE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ABORT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEAVE_LIMIT  = 3'd4;

  localparam int CFG_DATA_BITS = 16;
  localparam int LIMIT_BITS    = 8;
  localparam int VAR_BITS      = 16;

  // floor(v / 100) for any 16-bit v: (v * 83887) >> 23
  localparam int          DIV_MUL_BITS = 17;
  localparam logic [16:0] DIV_MUL      = 17'd83887;
  localparam int          DIV_SHIFT    = 23;
  localparam int          PROD_BITS    = VAR_BITS + DIV_MUL_BITS;
  localparam int          QUOT_BITS    = PROD_BITS - DIV_SHIFT;

  localparam logic [VAR_BITS-1:0]   RST_PRESENCE_THR = 16'd1000;
  localparam logic [VAR_BITS-1:0]   RST_CALIB_WINDOW = 16'd500;
  localparam logic [LIMIT_BITS-1:0] RST_LIMIT        = 8'd5;

  // one result item
  typedef struct packed {
    logic                calib_accepted;
    logic [VAR_BITS-1:0] disturbance;
    logic                indicator_on;
    logic                state_changed;
    logic [1:0]          occ_state;
  } result_t;

endpackage
`default_nettype wire

[src/magnetic_vehicle_presence_detector_core.sv]
// Magnetic vehicle presence detector.
// s_axis carries one magnetometer sample per beat: tdata holds sample_x and
// sample_y, tuser holds mode (0 detect, 1 calibrate the baseline).
// m_axis returns exactly one result beat for each input beat, in order.
// cfg_* writes the five setup registers by index; cfg_ready is always high
// and writes are meant to happen while no sample is in flight.
// Pipeline: input register, square stage, result register. The baseline
// is updated as an item leaves the input register and the parking state
// machine as it enters the result register, so every item sees the state
// left by the one before it. A beat passes all three registers before tvalid
// rises; one item per cycle is taken while the receiver does not stall.
// Each stage holds its beat while the stage after it is full and stalled;
// bubbles collapse, so the input side keeps taking beats until all three
// stages are full behind a stalled receiver.
// Reset clears the pipeline, baseline, counters and lamp and loads the
// register defaults (threshold 1000, window 500, limits 5).
`default_nettype none
module magnetic_vehicle_presence_detector_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [31:0]                       s_axis_tdata,  // sample_x[15:0], sample_y[31:16]
  input  wire                               s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // occ_state[1:0], state_changed[2], indicator_on[3], disturbance[19:4],
  // calib_accepted[20], zero fill [23:21]
  output logic [23:0]                       m_axis_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [mvpd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire  [mvpd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import mvpd_pkg::*;

  // configuration
  logic [VAR_BITS-1:0]   presence_thr;
  logic [VAR_BITS-1:0]   calib_window;
  logic [LIMIT_BITS-1:0] arrive_limit;
  logic [LIMIT_BITS-1:0] abort_limit;
  logic [LIMIT_BITS-1:0] leave_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_thr <= RST_PRESENCE_THR;
      calib_window <= RST_CALIB_WINDOW;
      arrive_limit <= RST_LIMIT;
      abort_limit  <= RST_LIMIT;
      leave_limit  <= RST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRESENCE_THR: presence_thr <= cfg_data;
        CFG_CALIB_WINDOW: calib_window <= cfg_data;
        CFG_ARRIVE_LIMIT: arrive_limit <= cfg_data[LIMIT_BITS-1:0];
        CFG_ABORT_LIMIT:  abort_limit  <= cfg_data[LIMIT_BITS-1:0];
        CFG_LEAVE_LIMIT:  leave_limit  <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v1, v2, v3;
  logic ready2, ready3;
  logic move2, move3;

  assign ready3        = !v3 || m_axis_tready;
  assign ready2        = !v2 || ready3;
  assign s_axis_tready = !v1 || ready2;
  assign move2         = v1 && ready2;
  assign move3         = v2 && ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_axis_tready) v1 <= s_axis_tvalid;
      if (ready2)        v2 <= v1;
      if (ready3)        v3 <= v2;
    end
  end

  // stage 1: input register
  logic                   mode1;
  logic [SAMPLE_BITS-1:0] sx1, sy1;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode1 <= s_axis_tuser;
      sx1   <= s_axis_tdata[SAMPLE_BITS-1:0];
      sy1   <= s_axis_tdata[16+SAMPLE_BITS-1:16];
    end
  end

  // stage 2: baseline compare and update, squared deviations
  logic [SAMPLE_BITS-1:0]   base_x, base_y;
  logic [SAMPLE_BITS-1:0]   dx, dy;
  logic [2*SAMPLE_BITS-1:0] sqx, sqy;
  logic [SAMPLE_BITS:0]     sum_x, sum_y;
  logic                     in_window;

  assign dx        = (sx1 >= base_x) ? sx1 - base_x : base_x - sx1;
  assign dy        = (sy1 >= base_y) ? sy1 - base_y : base_y - sy1;
  assign sqx       = (2*SAMPLE_BITS)'(dx) * (2*SAMPLE_BITS)'(dx);
  assign sqy       = (2*SAMPLE_BITS)'(dy) * (2*SAMPLE_BITS)'(dy);
  assign sum_x     = {1'b0, base_x} + {1'b0, sx1};
  assign sum_y     = {1'b0, base_y} + {1'b0, sy1};
  assign in_window = (17'(dx) < 17'(calib_window)) && (17'(dy) < 17'(calib_window));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x <= '0;
      base_y <= '0;
    end else if (move2 && mode1 && in_window) begin
      base_x <= sum_x[SAMPLE_BITS:1];
      base_y <= sum_y[SAMPLE_BITS:1];
    end
  end

  logic                mode2;
  logic                acc2;
  logic [VAR_BITS-1:0] vx2, vy2;

  always_ff @(posedge clk) begin
    if (move2) begin
      mode2 <= mode1;
      acc2  <= mode1 && in_window;
      vx2   <= sqx[VAR_BITS-1:0];
      vy2   <= sqy[VAR_BITS-1:0];
    end
  end

  // stage 3: disturbance and parking state machine
  logic [PROD_BITS-1:0] prod;
  logic [VAR_BITS-1:0]  vx_div;
  logic [VAR_BITS-1:0]  disturb;

  assign prod    = PROD_BITS'(vx2) * PROD_BITS'(DIV_MUL);
  assign vx_div  = VAR_BITS'(prod[PROD_BITS-1:DIV_SHIFT]);
  assign disturb = (vy2 >= vx_div) ? vy2 - vx_div : vx_div - vy2;

  logic [1:0]            park_state, park_state_next;
  logic [LIMIT_BITS-1:0] arrive_count, arrive_count_next;
  logic [LIMIT_BITS-1:0] abort_count, abort_count_next;
  logic [LIMIT_BITS-1:0] leave_count, leave_count_next;
  logic                  lamp, lamp_next;
  logic [LIMIT_BITS-1:0] arrive_inc, abort_inc, leave_inc;

  assign arrive_inc = arrive_count + LIMIT_BITS'(1);
  assign abort_inc  = abort_count + LIMIT_BITS'(1);
  assign leave_inc  = leave_count + LIMIT_BITS'(1);

  always_comb begin
    park_state_next   = park_state;
    arrive_count_next = arrive_count;
    abort_count_next  = abort_count;
    leave_count_next  = leave_count;
    lamp_next         = lamp;
    if (!mode2) begin
      if (disturb > presence_thr) begin
        if (park_state != ST_OCCUPIED) begin
          if (arrive_inc > arrive_limit) begin
            park_state_next   = ST_OCCUPIED;
            lamp_next         = 1'b1;
            arrive_count_next = '0;
          end else begin
            park_state_next   = ST_ARRIVING;
            arrive_count_next = arrive_inc;
          end
        end
      end else if (park_state == ST_ARRIVING) begin
        if (abort_inc > abort_limit) begin
          park_state_next   = ST_EMPTY;
          abort_count_next  = '0;
          arrive_count_next = '0;
        end else begin
          abort_count_next = abort_inc;
        end
      end else if (park_state != ST_EMPTY) begin
        if (leave_inc > leave_limit) begin
          park_state_next  = ST_EMPTY;
          lamp_next        = 1'b0;
          leave_count_next = '0;
        end else begin
          leave_count_next = leave_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      park_state   <= ST_EMPTY;
      arrive_count <= '0;
      abort_count  <= '0;
      leave_count  <= '0;
      lamp         <= 1'b0;
    end else if (move3) begin
      park_state   <= park_state_next;
      arrive_count <= arrive_count_next;
      abort_count  <= abort_count_next;
      leave_count  <= leave_count_next;
      lamp         <= lamp_next;
    end
  end

  result_t res3;

  always_ff @(posedge clk) begin
    if (move3) begin
      res3.occ_state      <= park_state_next;
      res3.state_changed  <= park_state_next != park_state;
      res3.indicator_on   <= lamp_next;
      res3.disturbance    <= mode2 ? '0 : disturb;
      res3.calib_accepted <= acc2;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {3'b000, res3};

  // checks
  a_lamp_tracks_occupied: assert property (@(posedge clk) disable iff (rst)
    lamp == (park_state == ST_OCCUPIED))
    else $error("lamp out of step with occupied state");

  a_calib_result_quiet: assert property (@(posedge clk) disable iff (rst)
    v3 && res3.calib_accepted |-> !res3.state_changed && res3.disturbance == '0)
    else $error("calibration result carries detect fields");

  a_base_only_on_calib: assert property (@(posedge clk) disable iff (rst)
    !(move2 && mode1) |=> $stable(base_x) && $stable(base_y))
    else $error("baseline moved without a calibration beat");

  a_state_only_on_detect: assert property (@(posedge clk) disable iff (rst)
    !(move3 && !mode2) |=> $stable(park_state))
    else $error("parking state moved without a detect beat");

endmodule
`default_nettype wire

[bench/tb_magnetic_vehicle_presence_detector_core.sv]
`default_nettype none
module tb_magnetic_vehicle_presence_detector_core;
  import mvpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_DETECT = 1'b0;
  localparam logic MODE_CALIB  = 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIR       = 27;

  typedef struct packed {
    logic        mode;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        typed;
    result_t     want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [31:0]              s_axis_tdata;   // sample_x[15:0], sample_y[31:16]
  logic                     s_axis_tuser;   // mode
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [23:0]              m_axis_tdata;   // result_t in [20:0], zero fill above
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  magnetic_vehicle_presence_detector_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // detector state as the testbench sees it
  logic [15:0] thr, win;
  logic [7:0]  lim_arrive, lim_abort, lim_leave;
  logic [15:0] bx, by;
  logic [1:0]  pst;
  logic [7:0]  cnt_arrive, cnt_abort, cnt_leave;
  logic        lamp_q;

  result_t     expected_q[$];
  int unsigned err_count = 0;
  int unsigned rx_count  = 0;
  bit          no_gaps   = 1'b0;
  bit          hold_done = 1'b0;
  bit          busy_run  = 1'b0;
  int          run_left  = 0;

  sample_row_t dir_tab [0:N_DIR-1];

  function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic result_t detector_step(input logic m, input logic [15:0] sx,
                                            input logic [15:0] sy);
    result_t     r;
    logic [1:0]  prior;
    logic [15:0] dx, dy, vx, vy;
    logic [31:0] sqx, sqy;
    logic [16:0] sumx, sumy;
    r = '0;
    prior = pst;
    if (m == MODE_CALIB) begin
      if (absdiff(bx, sx) < win && absdiff(by, sy) < win) begin
        sumx = {1'b0, bx} + {1'b0, sx};
        sumy = {1'b0, by} + {1'b0, sy};
        bx = sumx[16:1];
        by = sumy[16:1];
        r.calib_accepted = 1'b1;
      end
    end else begin
      dx = absdiff(sx, bx);
      dy = absdiff(sy, by);
      sqx = 32'(dx) * 32'(dx);
      sqy = 32'(dy) * 32'(dy);
      vx = sqx[15:0];
      vy = sqy[15:0];
      r.disturbance = absdiff(vy, vx / 16'd100);
      if (r.disturbance > thr) begin
        if (pst != ST_OCCUPIED) begin
          cnt_arrive = cnt_arrive + 8'd1;
          if (cnt_arrive > lim_arrive) begin
            pst = ST_OCCUPIED;
            lamp_q = 1'b1;
            cnt_arrive = '0;
          end else begin
            pst = ST_ARRIVING;
          end
        end
      end else if (pst == ST_ARRIVING) begin
        cnt_abort = cnt_abort + 8'd1;
        if (cnt_abort > lim_abort) begin
          pst = ST_EMPTY;
          cnt_abort = '0;
          cnt_arrive = '0;
        end
      end else if (pst != ST_EMPTY) begin
        cnt_leave = cnt_leave + 8'd1;
        if (cnt_leave > lim_leave) begin
          pst = ST_EMPTY;
          lamp_q = 1'b0;
          cnt_leave = '0;
        end
      end
      r.state_changed = (pst != prior);
    end
    r.occ_state = pst;
    r.indicator_on = lamp_q;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] near(input logic [15:0] base, input int span);
    logic [15:0] off;
    off = 16'($urandom_range(0, span));
    return $urandom_range(0, 1) ? base + off : base - off;
  endfunction

  task automatic send_sample(input logic m, input logic [15:0] sx, input logic [15:0] sy,
                             input logic typed, input result_t want);
    int      gap;
    result_t pred;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sy, sx};
    s_axis_tuser  <= m;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = detector_step(m, sx, sy);
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PRESENCE_THR: thr = val;
      CFG_CALIB_WINDOW: win = val;
      CFG_ARRIVE_LIMIT: lim_arrive = val[7:0];
      CFG_ABORT_LIMIT:  lim_abort = val[7:0];
      CFG_LEAVE_LIMIT:  lim_leave = val[7:0];
      default: ;
    endcase
  endtask

  // only called with the input side idle; wait for the pipe to empty first
  task automatic setup_phase(input logic [15:0] t, input logic [15:0] w,
                             input logic [15:0] la, input logic [15:0] lb,
                             input logic [15:0] ll, input bit poke_unused);
    while (expected_q.size() != 0) @(posedge clk);
    write_reg(CFG_PRESENCE_THR, t);
    write_reg(CFG_CALIB_WINDOW, w);
    write_reg(CFG_ARRIVE_LIMIT, la);
    write_reg(CFG_ABORT_LIMIT, lb);
    write_reg(CFG_LEAVE_LIMIT, ll);
    if (poke_unused) write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // runs of busy and quiet samples around the baseline, plus calibration and noise
  task automatic random_samples(input int count);
    int          r;
    logic        m;
    logic [15:0] sx, sy, dy;
    repeat (count) begin
      if (run_left == 0) begin
        busy_run = ~busy_run;
        run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                : $urandom_range(260, 320);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        m  = 1'($urandom_range(0, 1));
        sx = 16'($urandom);
        sy = 16'($urandom);
      end else if (r < 20) begin
        m  = MODE_CALIB;
        sx = near(bx, win);
        sy = near(by, win);
      end else begin
        m = MODE_DETECT;
        run_left--;
        if (busy_run) begin
          dy = 16'($urandom_range(40, 255));
          sx = near(bx, 20);
          sy = $urandom_range(0, 1) ? by + dy : by - dy;
        end else begin
          sx = near(bx, 30);
          sy = near(by, 3);
        end
      end
      send_sample(m, sx, sy, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic [15:0] t, w, la, lb, ll;
    case ($urandom_range(0, 3))
      0, 1: t = 16'($urandom_range(0, 3000));
      2:    t = 16'($urandom_range(100, 20000));
      default: t = 16'($urandom);
    endcase
    w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    la = {8'($urandom), ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12))};
    lb = {8'($urandom), ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12))};
    ll = {8'($urandom), ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12))};
    setup_phase(t, w, la, lb, ll, 1'($urandom_range(0, 1)));
    no_gaps = ($urandom_range(0, 3) == 0);
    random_samples(count);
  endtask

  // result side
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[20:0]);
      rx_count++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.occ_state != want.occ_state) begin
          $error("occ_state expected %0d got %0d", want.occ_state, got.occ_state);
          err_count++;
        end
        if (got.state_changed != want.state_changed) begin
          $error("state_changed expected %0d got %0d", want.state_changed, got.state_changed);
          err_count++;
        end
        if (got.indicator_on != want.indicator_on) begin
          $error("indicator_on expected %0d got %0d", want.indicator_on, got.indicator_on);
          err_count++;
        end
        if (got.disturbance != want.disturbance) begin
          $error("disturbance expected %0d got %0d", want.disturbance, got.disturbance);
          err_count++;
        end
        if (got.calib_accepted != want.calib_accepted) begin
          $error("calib_accepted expected %0d got %0d", want.calib_accepted,
                 got.calib_accepted);
          err_count++;
        end
      end
    end
  end

  // receiver: random back-pressure, one long hold-off mid-run
  initial begin : rx_side
    int len;
    m_axis_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && rx_count >= 600) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      len = idle_len();
      if (len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_magnetic_vehicle_presence_detector_core: done, errors");
    $finish;
  end

  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_DETECT;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_PRESENCE_THR;
    cfg_data      = '0;

    thr = RST_PRESENCE_THR;
    win = RST_CALIB_WINDOW;
    lim_arrive = RST_LIMIT;
    lim_abort  = RST_LIMIT;
    lim_leave  = RST_LIMIT;
    bx = '0;
    by = '0;
    pst = ST_EMPTY;
    cnt_arrive = '0;
    cnt_abort  = '0;
    cnt_leave  = '0;
    lamp_q = 1'b0;

    // reset defaults: threshold 1000, window 500, limits 5
    dir_tab = '{
      '{MODE_DETECT, 16'd0,     16'd0,     1'b1, '{1'b0, 16'd0,     1'b0, 1'b0, ST_EMPTY}},
      '{MODE_CALIB,  16'd0,     16'd0,     1'b1, '{1'b1, 16'd0,     1'b0, 1'b0, ST_EMPTY}},
      // square of 0xffff keeps only its low bits
      '{MODE_DETECT, 16'd0,     16'hffff,  1'b1, '{1'b0, 16'd1,     1'b0, 1'b0, ST_EMPTY}},
      '{MODE_DETECT, 16'hffff,  16'd0,     1'b1, '{1'b0, 16'd0,     1'b0, 1'b0, ST_EMPTY}},
      '{MODE_DETECT, 16'd0,     16'd255,   1'b1, '{1'b0, 16'd65025, 1'b0, 1'b1, ST_ARRIVING}},
      // window edge: just inside, exactly on it, Y outside
      '{MODE_CALIB,  16'd499,   16'd0,     1'b0, '0},
      '{MODE_CALIB,  16'd749,   16'd0,     1'b0, '0},
      '{MODE_CALIB,  16'd249,   16'd1000,  1'b0, '0},
      '{MODE_DETECT, 16'd249,   16'd255,   1'b0, '0},
      '{MODE_DETECT, 16'd249,   16'd255,   1'b0, '0},
      '{MODE_DETECT, 16'd249,   16'd255,   1'b0, '0},
      '{MODE_DETECT, 16'd249,   16'd255,   1'b0, '0},
      '{MODE_DETECT, 16'd249,   16'd255,   1'b0, '0},
      '{MODE_DETECT, 16'd249,   16'd255,   1'b0, '0},
      // X deviation dominates: vx/100 above vy
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      // arrival that gets abandoned
      '{MODE_DETECT, 16'd249,   16'd255,   1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0},
      '{MODE_DETECT, 16'd449,   16'd0,     1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++)
      send_sample(dir_tab[i].mode, dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].typed,
                  dir_tab[i].want);
    s_axis_tvalid <= 1'b0;

    // low extremes: any nonzero disturbance is a vehicle, calibration samples inside the 0xffff window calibrate
    setup_phase(16'd0, 16'hffff, 16'd0, 16'd0, 16'd0, 1'b0);
    random_samples(200);
    // high extremes: nothing is a vehicle, no sample calibrates
    setup_phase(16'hffff, 16'd0, 16'd254, 16'd254, 16'd254, 1'b0);
    random_samples(150);
    // limit 255 through the low byte: arrive and abort counters wrap
    setup_phase(16'd1000, 16'd500, 16'h12ff, 16'hc3ff, 16'd5, 1'b1);
    random_samples(450);
    // quick occupancy, leave counter wraps
    setup_phase(16'd500, 16'd2000, 16'd0, 16'd3, 16'h00ff, 1'b0);
    random_samples(400);
    repeat (4) random_phase(190);

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("tb_magnetic_vehicle_presence_detector_core: done, clean");
    else
      $display("tb_magnetic_vehicle_presence_detector_core: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
src/mvpd_pkg.sv
src/magnetic_vehicle_presence_detector_core.sv
bench/tb_magnetic_vehicle_presence_detector_core.sv
